/* hw/rtl/fvg_pkg.sv */
// Shared types, constants and helper functions for the FAT volume geometry block.
// Used by the divider, datapath, controller and top level. No dependencies.
package fvg_pkg;

  localparam int DIVW = 36;                 // dividend / quotient width of the serial divider
  localparam int MAX_PASSES_DEF = 10;

  localparam logic [1:0] FT_AUTO = 2'd0;
  localparam logic [1:0] FT12    = 2'd1;
  localparam logic [1:0] FT16    = 2'd2;
  localparam logic [1:0] FT32    = 2'd3;

  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;

  localparam logic [47:0] MIB32  = 48'd33554432;
  localparam logic [47:0] MIB64  = 48'd67108864;
  localparam logic [47:0] MIB128 = 48'd134217728;
  localparam logic [47:0] GIB8   = 48'd8589934592;
  localparam logic [47:0] GIB16  = 48'd17179869184;
  localparam logic [47:0] GIB32  = 48'd34359738368;

  typedef enum logic [1:0] {
    DSEL_SPC,
    DSEL_ROOT,
    DSEL_FAT
  } dsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CB,
    ST_SPC_GO,
    ST_SPC_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_PASS,
    ST_CLUS,
    ST_DECIDE,
    ST_FAT_GO,
    ST_FAT_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  prep;
    logic  pick_cb;
    logic  div_go;
    dsel_t div_sel;
    logic  take_spc;
    logic  take_root;
    logic  pass_used;
    logic  pass_clus;
    logic  promote;
    logic  take_fat;
    logic  mark_fail;
    logic  publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero;
    logic spc_bad;
    logic over;
    logic promote;
    logic last;
    logic fixed;
  } stat_t;

  function automatic logic [20:0] auto_cluster(input logic [47:0] vb);
    logic [20:0] r;
    if (vb <= MIB32) r = 21'd512;
    else if (vb <= MIB64) r = 21'd1024;
    else if (vb <= MIB128) r = 21'd2048;
    else if (vb <= GIB8) r = 21'd4096;
    else if (vb <= GIB16) r = 21'd8192;
    else if (vb <= GIB32) r = 21'd16384;
    else r = 21'd32768;
    return r;
  endfunction

  function automatic logic [1:0] type_of(input logic [31:0] clus);
    logic [1:0] r;
    if (clus < FAT12_LIMIT) r = FT12;
    else if (clus < FAT16_LIMIT) r = FT16;
    else r = FT32;
    return r;
  endfunction

endpackage

/* hw/rtl/fvg_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on fvg_pkg for the dividend width.
module fvg_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fvg_pkg::DIVW-1:0] dividend,
  input  logic [15:0]              divisor,
  output logic                     done,
  output logic [fvg_pkg::DIVW-1:0] quotient
);

  localparam int CW = $clog2(fvg_pkg::DIVW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [15:0]   rem;
  logic [16:0]   trial;
  logic          qbit;
  logic [15:0]   rem_next;

  always_comb begin
    trial    = {rem, quotient[fvg_pkg::DIVW-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? 16'(trial - {1'b0, divisor}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(fvg_pkg::DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[fvg_pkg::DIVW-2:0], qbit};
    end
  end

endmodule

/* hw/rtl/fvg_datapath.sv */
// Datapath: request registers, layout registers, FAT iteration and result registers.
// Depends on fvg_pkg and fvg_div.
module fvg_datapath #(
  parameter int MAX_PASSES = fvg_pkg::MAX_PASSES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fvg_pkg::cmd_t       cmd,
  output fvg_pkg::stat_t      stat,
  input  logic [31:0]         volume_sectors,
  input  logic [15:0]         sector_bytes,
  input  logic [1:0]          wanted_type,
  input  logic [20:0]         wanted_cluster_bytes,
  output logic                status,
  output logic [1:0]          chosen_type,
  output logic [7:0]          cluster_sectors,
  output logic [20:0]         cluster_bytes,
  output logic [5:0]          reserved_count,
  output logic [9:0]          root_entries,
  output logic [31:0]         table_sectors,
  output logic [31:0]         payload_sectors,
  output logic [31:0]         cluster_total
);

  localparam int DW = fvg_pkg::DIVW;
  localparam int PW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  logic [31:0]   vol;
  logic [15:0]   sb;
  logic [1:0]    want;
  logic [20:0]   wcb;
  logic [47:0]   vol_bytes;
  logic [20:0]   cb;
  logic [7:0]    spc;
  logic [2:0]    shamt;
  logic [5:0]    reserved;
  logic [9:0]    entries;
  logic [14:0]   rootdir;
  logic [DW-1:0] fat;
  logic [31:0]   data;
  logic [31:0]   clusters;
  logic [1:0]    typ;
  logic [PW-1:0] pass;
  logic          fail;

  logic [DW-1:0] dividend;
  logic [DW-1:0] quo;
  logic          div_done;
  logic [37:0]   used;
  logic [DW-1:0] clus_p2;
  logic [DW-1:0] scaled;
  logic [31:0]   clus_shift;
  logic [2:0]    shamt_next;
  logic          bad_final;

  fvg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (dividend),
    .divisor  (sb),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    clus_p2 = DW'(clusters) + DW'(2);
    scaled  = (typ == fvg_pkg::FT32) ? {clus_p2[DW-3:0], 2'b00} : {clus_p2[DW-2:0], 1'b0};
    case (cmd.div_sel)
      fvg_pkg::DSEL_SPC:  dividend = DW'(cb);
      fvg_pkg::DSEL_ROOT: dividend = DW'({entries, 5'b00000}) + DW'(sb) - DW'(1);
      fvg_pkg::DSEL_FAT:  dividend = scaled + DW'(sb) - DW'(1);
      default:            dividend = DW'(cb);
    endcase
  end

  always_comb begin
    used       = 38'(reserved) + 38'({fat, 1'b0}) + 38'(rootdir);
    clus_shift = data >> shamt;
    shamt_next = '0;
    for (int i = 0; i < 8; i++) begin
      if (quo[i]) shamt_next = 3'(i);
    end
    stat.div_done = div_done;
    stat.zero     = (vol == '0) || (sb == '0);
    stat.spc_bad  = (quo == '0) || (quo > DW'(128)) || ((quo & (quo - DW'(1))) != '0);
    stat.over     = used > 38'(vol);
    stat.promote  = (typ == fvg_pkg::FT32) && (reserved == 6'd1);
    stat.last     = (pass == PW'(MAX_PASSES - 1));
    stat.fixed    = (quo == fat);
  end

  // final consistency of cluster count, type and table size
  always_comb begin
    bad_final = fail || (clusters < 32'd2) || (fat[DW-1:32] != '0);
    case (typ)
      fvg_pkg::FT12: if (clusters >= fvg_pkg::FAT12_LIMIT) bad_final = 1'b1;
      fvg_pkg::FT16: if (clusters < fvg_pkg::FAT12_LIMIT || clusters >= fvg_pkg::FAT16_LIMIT)
                       bad_final = 1'b1;
      fvg_pkg::FT32: if (clusters < fvg_pkg::FAT16_LIMIT) bad_final = 1'b1;
      default:       bad_final = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vol      <= volume_sectors;
      sb       <= sector_bytes;
      want     <= wanted_type;
      wcb      <= wanted_cluster_bytes;
      fat      <= '0;
      pass     <= '0;
      fail     <= 1'b0;
      clusters <= '0;
      typ      <= fvg_pkg::FT_AUTO;
    end
    if (cmd.prep) vol_bytes <= vol * 48'(sb);
    if (cmd.pick_cb) begin
      cb       <= (wcb != '0) ? wcb : fvg_pkg::auto_cluster(vol_bytes);
      reserved <= (want == fvg_pkg::FT32) ? 6'd32 : 6'd1;
      entries  <= (want == fvg_pkg::FT32) ? 10'd0 :
                  (vol_bytes <= fvg_pkg::MIB32) ? 10'd224 : 10'd512;
    end
    if (cmd.take_spc) begin
      spc   <= quo[7:0];
      shamt <= shamt_next;
    end
    if (cmd.take_root) rootdir <= quo[14:0];
    if (cmd.pass_used) data <= vol - used[31:0];
    if (cmd.pass_clus) begin
      clusters <= clus_shift;
      typ      <= (want != fvg_pkg::FT_AUTO) ? want : fvg_pkg::type_of(clus_shift);
    end
    if (cmd.promote) begin
      reserved <= 6'd32;
      entries  <= '0;
      rootdir  <= '0;
      pass     <= pass + PW'(1);
    end
    if (cmd.take_fat) begin
      fat  <= quo;
      pass <= pass + PW'(1);
    end
    if (cmd.mark_fail) fail <= 1'b1;
    if (cmd.publish) begin
      status          <= bad_final;
      chosen_type     <= bad_final ? 2'd0  : typ;
      cluster_sectors <= bad_final ? 8'd0  : spc;
      cluster_bytes   <= bad_final ? 21'd0 : cb;
      reserved_count  <= bad_final ? 6'd0  : reserved;
      root_entries    <= bad_final ? 10'd0 : entries;
      table_sectors   <= bad_final ? 32'd0 : fat[31:0];
      payload_sectors <= bad_final ? 32'd0 : data;
      cluster_total   <= bad_final ? 32'd0 : clusters;
    end
  end

endmodule

/* hw/rtl/fvg_ctrl.sv */
// Controller state machine: sequences the layout steps, FAT passes and result transfer.
// Depends on fvg_pkg.
module fvg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  fvg_pkg::stat_t stat,
  output fvg_pkg::cmd_t  cmd
);

  fvg_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != fvg_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      fvg_pkg::ST_IDLE:     if (in_valid) state_next = fvg_pkg::ST_PREP;
      fvg_pkg::ST_PREP:     state_next = stat.zero ? fvg_pkg::ST_DONE : fvg_pkg::ST_CB;
      fvg_pkg::ST_CB:       state_next = fvg_pkg::ST_SPC_GO;
      fvg_pkg::ST_SPC_GO:   state_next = fvg_pkg::ST_SPC_WAIT;
      fvg_pkg::ST_SPC_WAIT:
        if (stat.div_done) state_next = stat.spc_bad ? fvg_pkg::ST_DONE : fvg_pkg::ST_ROOT_GO;
      fvg_pkg::ST_ROOT_GO:  state_next = fvg_pkg::ST_ROOT_WAIT;
      fvg_pkg::ST_ROOT_WAIT: if (stat.div_done) state_next = fvg_pkg::ST_PASS;
      fvg_pkg::ST_PASS:     state_next = stat.over ? fvg_pkg::ST_DONE : fvg_pkg::ST_CLUS;
      fvg_pkg::ST_CLUS:     state_next = fvg_pkg::ST_DECIDE;
      fvg_pkg::ST_DECIDE:
        if (stat.promote) state_next = stat.last ? fvg_pkg::ST_DONE : fvg_pkg::ST_PASS;
        else state_next = fvg_pkg::ST_FAT_GO;
      fvg_pkg::ST_FAT_GO:   state_next = fvg_pkg::ST_FAT_WAIT;
      fvg_pkg::ST_FAT_WAIT:
        if (stat.div_done)
          state_next = (stat.fixed || stat.last) ? fvg_pkg::ST_DONE : fvg_pkg::ST_PASS;
      fvg_pkg::ST_DONE:     if (out_free) state_next = fvg_pkg::ST_IDLE;
      default:              state_next = fvg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = fvg_pkg::DSEL_SPC;
    case (state)
      fvg_pkg::ST_IDLE:      cmd.load = in_valid;
      fvg_pkg::ST_PREP: begin
        cmd.prep      = 1'b1;
        cmd.mark_fail = stat.zero;
      end
      fvg_pkg::ST_CB:        cmd.pick_cb = 1'b1;
      fvg_pkg::ST_SPC_GO:    cmd.div_go = 1'b1;
      fvg_pkg::ST_SPC_WAIT: begin
        cmd.take_spc  = stat.div_done && !stat.spc_bad;
        cmd.mark_fail = stat.div_done && stat.spc_bad;
      end
      fvg_pkg::ST_ROOT_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = fvg_pkg::DSEL_ROOT;
      end
      fvg_pkg::ST_ROOT_WAIT: cmd.take_root = stat.div_done;
      fvg_pkg::ST_PASS: begin
        cmd.pass_used = !stat.over;
        cmd.mark_fail = stat.over;
      end
      fvg_pkg::ST_CLUS:      cmd.pass_clus = 1'b1;
      fvg_pkg::ST_DECIDE:    cmd.promote = stat.promote;
      fvg_pkg::ST_FAT_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = fvg_pkg::DSEL_FAT;
      end
      fvg_pkg::ST_FAT_WAIT:  cmd.take_fat = stat.div_done;
      fvg_pkg::ST_DONE:      cmd.publish = out_free;
      default:               cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.publish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fvg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/fat_volume_geometry_calc.sv */
// FAT volume geometry calculator. One request (volume size, sector size, wanted type,
// wanted cluster size) gives one layout result, or status 1 with all other fields zero.
// One request is worked at a time; in_stall is high from acceptance until the result
// enters the output register. All divisions share the one serial divider: setup divides
// for the cluster size and the root directory, then up to MAX_PASSES FAT passes follow
// (a pass that only promotes to FAT32 has no division), then the result is published.
// A zero size or a bad cluster size ends the request early with status 1.
// A finished result waits until the output register is free; the next request is
// taken once the result has entered the output register.
// Depends on fvg_pkg, fvg_ctrl, fvg_datapath and fvg_div.
module fat_volume_geometry_calc #(
  parameter int MAX_PASSES = fvg_pkg::MAX_PASSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] volume_sectors,
  input  logic [15:0] sector_bytes,
  input  logic [1:0]  wanted_type,
  input  logic [20:0] wanted_cluster_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [1:0]  chosen_type,
  output logic [7:0]  cluster_sectors,
  output logic [20:0] cluster_bytes,
  output logic [5:0]  reserved_count,
  output logic [9:0]  root_entries,
  output logic [31:0] table_sectors,
  output logic [31:0] payload_sectors,
  output logic [31:0] cluster_total
);

  fvg_pkg::cmd_t  cmd;
  fvg_pkg::stat_t stat;

  fvg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fvg_datapath #(
    .MAX_PASSES (MAX_PASSES)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .volume_sectors       (volume_sectors),
    .sector_bytes         (sector_bytes),
    .wanted_type          (wanted_type),
    .wanted_cluster_bytes (wanted_cluster_bytes),
    .status               (status),
    .chosen_type          (chosen_type),
    .cluster_sectors      (cluster_sectors),
    .cluster_bytes        (cluster_bytes),
    .reserved_count       (reserved_count),
    .root_entries         (root_entries),
    .table_sectors        (table_sectors),
    .payload_sectors      (payload_sectors),
    .cluster_total        (cluster_total)
  );

`ifndef NO_ASSERTIONS
  // busy right after a request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while not busy afterwards");

  a_error_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (chosen_type == 2'd0 && table_sectors == 32'd0 &&
                               cluster_total == 32'd0))
    else $error("error result carries nonzero fields");

  a_ok_layout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> (chosen_type != 2'd0 && $onehot(cluster_sectors)))
    else $error("good result with bad type or cluster size");
`endif

endmodule
